// ===== rtl/dvr_pkg.sv =====
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared widths, register indexes, phase codes and types of the ramp core.
// ----------------------------------------------------------------------------
package dvr_pkg;

    // Field widths
    localparam int DIST_W  = 32;
    localparam int VEL_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int MAXP_W  = 15;
    localparam int PHASE_W = 2;

    // APB port
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // Datapath widths
    localparam int PROD_W     = DIST_W + GAIN_W;       // |T| * gain
    localparam int PEAK_SHIFT = 13;
    localparam int PEAK_W     = PROD_W - PEAK_SHIFT;   // peak magnitude
    localparam int COEF_W     = PEAK_W + 3;            // signed slope and offset
    localparam int HALF_W     = 18;
    localparam int AMAG_W     = 2 * HALF_W;            // slope magnitude
    localparam int BMAG_W     = DIST_W + 1;            // |2d|
    localparam int PP_W       = HALF_W + BMAG_W;       // one partial product
    localparam int DVD_W      = AMAG_W + BMAG_W;       // full dividend
    localparam int QUO_W      = 41;                    // quotient bits kept
    localparam int REM_W      = DIST_W;                // divider remainder
    localparam int SUM_W      = 46;                    // velocity before clamps

    // Register indexes
    localparam logic [IDX_W-1:0] REG_TOTAL_DISTANCE = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_VELOCITY = 3'd1;
    localparam logic [IDX_W-1:0] REG_END_VELOCITY   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ACCEL_GAIN     = 3'd3;
    localparam logic [IDX_W-1:0] REG_DECEL_GAIN     = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_NEG_VEL    = 3'd5;
    localparam logic [IDX_W-1:0] REG_MAX_POS_VEL    = 3'd6;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_RISE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FALL  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CREEP = 2'd2;
    localparam logic [PHASE_W-1:0] PH_ZERO  = 2'd3;

    // Creep velocity and minimum creep window, Q4.12 m/s
    localparam int MIN_CREEP_NEG = -410;
    localparam int MIN_CREEP_POS = 410;
    localparam int CREEP_STEP    = 410;

    typedef struct packed {
        logic signed [DIST_W-1:0] total_distance;
        logic signed [VEL_W-1:0]  start_velocity;
        logic signed [VEL_W-1:0]  end_velocity;
        logic [GAIN_W-1:0]        accel_gain;
        logic [GAIN_W-1:0]        decel_gain;
        logic signed [VEL_W-1:0]  max_negative_velocity;
        logic [MAXP_W-1:0]        max_positive_velocity;
    } t_cfg;

    // Data that rides alongside the division
    typedef struct packed {
        logic [PHASE_W-1:0]       phase;
        logic                     neg;
        logic signed [COEF_W-1:0] offset;
    } t_side;

endpackage

// ===== rtl/dvr_if.sv =====
// ----------------------------------------------------------------------------
// dvr_if
// Valid/ready channels for distance words in and velocity words out.
// ----------------------------------------------------------------------------
interface dvr_in_if;
    import dvr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] travelled_distance;
    modport source (output valid, output travelled_distance, input ready);
    modport sink   (input valid, input travelled_distance, output ready);
endinterface

interface dvr_out_if;
    import dvr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [VEL_W-1:0]  velocity;
    logic [PHASE_W-1:0]       phase;
    modport source (output valid, output velocity, output phase, input ready);
    modport sink   (input valid, input velocity, input phase, output ready);
endinterface

// ===== rtl/dvr_regs.sv =====
// ----------------------------------------------------------------------------
// dvr_regs
// APB configuration registers of the ramp core.
// ----------------------------------------------------------------------------
module dvr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dvr_pkg::ADDR_W-1:0]  paddr,
    input  logic [dvr_pkg::DATA_W-1:0]  pwdata,
    output logic [dvr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output dvr_pkg::t_cfg               o_cfg
);
    import dvr_pkg::*;

    t_cfg             r_cfg;
    logic             w_wr;
    logic [IDX_W-1:0] w_idx;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_distance        <= '0;
            r_cfg.start_velocity        <= '0;
            r_cfg.end_velocity          <= '0;
            r_cfg.accel_gain            <= GAIN_W'(128);
            r_cfg.decel_gain            <= GAIN_W'(128);
            r_cfg.max_negative_velocity <= -VEL_W'(4096);
            r_cfg.max_positive_velocity <= MAXP_W'(4096);
        end else if (w_wr) begin
            case (w_idx)
                REG_TOTAL_DISTANCE: r_cfg.total_distance <= pwdata[DIST_W-1:0];
                REG_START_VELOCITY: r_cfg.start_velocity <= pwdata[VEL_W-1:0];
                REG_END_VELOCITY:   r_cfg.end_velocity   <= pwdata[VEL_W-1:0];
                REG_ACCEL_GAIN:     r_cfg.accel_gain     <= pwdata[GAIN_W-1:0];
                REG_DECEL_GAIN:     r_cfg.decel_gain     <= pwdata[GAIN_W-1:0];
                REG_MAX_NEG_VEL:    r_cfg.max_negative_velocity <= pwdata[VEL_W-1:0];
                REG_MAX_POS_VEL:    r_cfg.max_positive_velocity <= pwdata[MAXP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TOTAL_DISTANCE: prdata = r_cfg.total_distance;
            REG_START_VELOCITY: prdata = {{(DATA_W-VEL_W){r_cfg.start_velocity[VEL_W-1]}},
                                          r_cfg.start_velocity};
            REG_END_VELOCITY:   prdata = {{(DATA_W-VEL_W){r_cfg.end_velocity[VEL_W-1]}},
                                          r_cfg.end_velocity};
            REG_ACCEL_GAIN:     prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.accel_gain};
            REG_DECEL_GAIN:     prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.decel_gain};
            REG_MAX_NEG_VEL:    prdata = {{(DATA_W-VEL_W){r_cfg.max_negative_velocity[VEL_W-1]}},
                                          r_cfg.max_negative_velocity};
            REG_MAX_POS_VEL:    prdata = {{(DATA_W-MAXP_W){1'b0}}, r_cfg.max_positive_velocity};
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/dvr_front.sv =====
// ----------------------------------------------------------------------------
// dvr_front
// Side decision, peak velocity, slope and the split product with 2d.
// ----------------------------------------------------------------------------
module dvr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dvr_pkg::t_cfg                     i_cfg,
    input  logic [dvr_pkg::DIST_W-1:0]        i_tmag,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic signed [dvr_pkg::DIST_W-1:0] i_dist,
    output logic                              o_valid,
    output logic [dvr_pkg::DVD_W-1:0]         o_dvd,
    output dvr_pkg::t_side                    o_side
);
    import dvr_pkg::*;

    logic [3:0] r_vld;

    // Stage 1: side, gain select, |T| * gain
    logic [DIST_W-1:0]  w_dmag;
    logic               w_rise, w_tpos, w_tneg, w_dpos, w_dneg, w_zero;
    logic [GAIN_W-1:0]  w_gain;
    logic [PHASE_W-1:0] w_phase;
    logic [PROD_W-1:0]  r1_m;
    logic [BMAG_W-1:0]  r1_bmag;
    logic               r1_rise, r1_dneg;
    logic [PHASE_W-1:0] r1_phase;

    assign w_dmag = i_dist[DIST_W-1] ? DIST_W'(-i_dist) : DIST_W'(i_dist);
    assign w_rise = {w_dmag, 1'b0} <= {1'b0, i_tmag};
    assign w_gain = w_rise ? i_cfg.accel_gain : i_cfg.decel_gain;
    assign w_zero = i_cfg.total_distance == '0;
    assign w_tneg = i_cfg.total_distance[DIST_W-1];
    assign w_tpos = !w_tneg && !w_zero;
    assign w_dneg = i_dist[DIST_W-1];
    assign w_dpos = !w_dneg && (i_dist != '0);

    always_comb begin
        if (w_zero) begin
            w_phase = PH_ZERO;
        end else if ((w_dneg && w_tpos) || (w_dpos && w_tneg)) begin
            w_phase = PH_CREEP;
        end else if (w_rise) begin
            w_phase = PH_RISE;
        end else begin
            w_phase = PH_FALL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_m     <= {{GAIN_W{1'b0}}, i_tmag} * {{DIST_W{1'b0}}, w_gain};
            r1_bmag  <= {w_dmag, 1'b0};
            r1_rise  <= w_rise;
            r1_dneg  <= w_dneg;
            r1_phase <= w_phase;
        end
    end

    // Stage 2: signed peak, slope and offset
    logic signed [COEF_W-1:0] w_peak, w_start, w_end, w_a, w_c;
    logic [AMAG_W-1:0]        r2_amag;
    logic [BMAG_W-1:0]        r2_bmag;
    t_side                    r2_side;

    always_comb begin
        w_peak  = {3'b000, r1_m[PROD_W-1:PEAK_SHIFT]};
        if (w_tneg) begin
            w_peak = -w_peak;
        end
        w_start = {{(COEF_W-VEL_W){i_cfg.start_velocity[VEL_W-1]}}, i_cfg.start_velocity};
        w_end   = {{(COEF_W-VEL_W){i_cfg.end_velocity[VEL_W-1]}}, i_cfg.end_velocity};
        if (r1_rise) begin
            w_a = w_peak - w_start;
            w_c = w_start;
        end else begin
            w_a = w_end - w_peak;
            w_c = (w_peak <<< 1) - w_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_amag        <= w_a[COEF_W-1] ? AMAG_W'(-w_a) : AMAG_W'(w_a);
            r2_bmag        <= r1_bmag;
            r2_side.phase  <= r1_phase;
            r2_side.neg    <= w_a[COEF_W-1] ^ r1_dneg ^ w_tneg;
            r2_side.offset <= w_c;
        end
    end

    // Stage 3: two partial products of |a| * |2d|
    logic [PP_W-1:0] r3_pp0, r3_pp1;
    t_side           r3_side;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_pp0  <= {{(PP_W-HALF_W){1'b0}}, r2_amag[HALF_W-1:0]}
                     * {{(PP_W-BMAG_W){1'b0}}, r2_bmag};
            r3_pp1  <= {{(PP_W-HALF_W){1'b0}}, r2_amag[AMAG_W-1:HALF_W]}
                     * {{(PP_W-BMAG_W){1'b0}}, r2_bmag};
            r3_side <= r2_side;
        end
    end

    // Stage 4: sum of the partial products
    logic [DVD_W-1:0] r4_dvd;
    t_side            r4_side;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_dvd  <= {{(DVD_W-PP_W){1'b0}}, r3_pp0} + {r3_pp1, {HALF_W{1'b0}}};
            r4_side <= r3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];
    assign o_dvd   = r4_dvd;
    assign o_side  = r4_side;

endmodule

// ===== rtl/dvr_div.sv =====
// ----------------------------------------------------------------------------
// dvr_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module dvr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [dvr_pkg::DVD_W-1:0]   i_dvd,
    input  dvr_pkg::t_side              i_side,
    input  logic [dvr_pkg::REM_W-1:0]   i_divisor,
    output logic                        o_valid,
    output logic [dvr_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_sat,
    output dvr_pkg::t_side              o_side
);
    import dvr_pkg::*;

    logic [REM_W-1:0] r_rem  [0:QUO_W];
    logic [QUO_W-1:0] r_x    [0:QUO_W];
    logic             r_sat  [0:QUO_W];
    t_side            r_side [0:QUO_W];
    logic [QUO_W:0]   r_vld;

    // The quotient overflows the kept bits when the top part of the dividend
    // already reaches the divisor.
    logic [REM_W-1:0] w_top;
    assign w_top = {{(REM_W-(DVD_W-QUO_W)){1'b0}}, i_dvd[DVD_W-1:QUO_W]};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= w_top;
            r_x[0]    <= i_dvd[QUO_W-1:0];
            r_sat[0]  <= w_top >= i_divisor;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [REM_W:0] w_t, w_d;
        logic           w_ge;
        assign w_t  = {r_rem[k], r_x[k][QUO_W-1]};
        assign w_d  = w_t - {1'b0, i_divisor};
        assign w_ge = w_t >= {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k+1]  <= w_ge ? w_d[REM_W-1:0] : w_t[REM_W-1:0];
                r_x[k+1]    <= {r_x[k][QUO_W-2:0], w_ge};
                r_sat[k+1]  <= r_sat[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[QUO_W-1:0], i_valid};
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo   = r_x[QUO_W];
    assign o_sat   = r_sat[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

// ===== rtl/dvr_back.sv =====
// ----------------------------------------------------------------------------
// dvr_back
// Offset add, creep override, creep window and limit clamps.
// ----------------------------------------------------------------------------
module dvr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dvr_pkg::t_cfg                     i_cfg,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic [dvr_pkg::QUO_W-1:0]         i_quo,
    input  logic                              i_sat,
    input  dvr_pkg::t_side                    i_side,
    output logic                              o_valid,
    output logic signed [dvr_pkg::VEL_W-1:0]  o_velocity,
    output logic [dvr_pkg::PHASE_W-1:0]       o_phase
);
    import dvr_pkg::*;

    logic [1:0] r_vld;

    // Stage A: signed quotient plus offset
    logic [QUO_W:0]          w_q;
    logic signed [SUM_W-1:0] w_qx, w_cx;
    logic signed [SUM_W-1:0] ra_sum;
    logic [PHASE_W-1:0]      ra_phase;

    assign w_q  = i_sat ? {1'b1, {QUO_W{1'b0}}} : {1'b0, i_quo};
    assign w_qx = {{(SUM_W-QUO_W-1){1'b0}}, w_q};
    assign w_cx = {{(SUM_W-COEF_W){i_side.offset[COEF_W-1]}}, i_side.offset};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            ra_sum   <= i_side.neg ? w_cx - w_qx : w_cx + w_qx;
            ra_phase <= i_side.phase;
        end
    end

    // Stage B: special cases and clamps
    logic signed [SUM_W-1:0] w_v, w_maxp, w_maxn;
    logic                    w_tpos;
    logic signed [VEL_W-1:0] rb_vel;
    logic [PHASE_W-1:0]      rb_phase;

    assign w_tpos = !i_cfg.total_distance[DIST_W-1] && (i_cfg.total_distance != '0);
    assign w_maxp = {{(SUM_W-MAXP_W){1'b0}}, i_cfg.max_positive_velocity};
    assign w_maxn = {{(SUM_W-VEL_W){i_cfg.max_negative_velocity[VEL_W-1]}},
                     i_cfg.max_negative_velocity};

    always_comb begin
        w_v = ra_sum;
        if (ra_phase == PH_CREEP) begin
            w_v = w_tpos ? SUM_W'(CREEP_STEP) : -SUM_W'(CREEP_STEP);
        end
        if (w_v > SUM_W'(MIN_CREEP_NEG) && w_v < SUM_W'(MIN_CREEP_POS)) begin
            w_v = w_tpos ? SUM_W'(MIN_CREEP_POS) : SUM_W'(MIN_CREEP_NEG);
        end
        if (w_v > w_maxp) begin
            w_v = w_maxp;
        end
        if (w_v < w_maxn) begin
            w_v = w_maxn;
        end
        if (ra_phase == PH_ZERO) begin
            w_v = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            rb_vel   <= w_v[VEL_W-1:0];
            rb_phase <= ra_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    assign o_valid    = r_vld[1];
    assign o_velocity = rb_vel;
    assign o_phase    = rb_phase;

endmodule

// ===== rtl/distance_velocity_ramp_core.sv =====
// ----------------------------------------------------------------------------
// distance_velocity_ramp_core
// Triangular, distance-based velocity ramp with creep and limit clamping.
// ----------------------------------------------------------------------------
// Usage:
// Each word on i_in carries a travelled distance (Q16.16 m); for each one the
// block returns one word on o_out with the commanded velocity (Q4.12 m/s) and
// the phase (rising, falling, wrong-direction creep or zero segment).
// Both channels are valid/ready; a word moves when valid and ready are high.
// The segment and its limits are set over the APB port, register i at byte
// address 4*i, while no word is in flight. pready is always high.
// From input word to output word the pipeline has four front stages
// (side and peak, slope, split product, product sum), one divider load stage,
// 41 divider stages with one quotient bit each, and two output stages.
// Throughput is one word per clock while the skid register is free; the divider chain sets the latency.
// When the receiver stalls, the last result moves into a one-word skid
// register, so one more input word is taken before i_in.ready drops; the
// whole pipeline then holds until the skid word is taken.
// Reset clears every valid bit and the skid register and loads the register
// reset values; no output word is shown until a new input word has passed.
// ----------------------------------------------------------------------------
module distance_velocity_ramp_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dvr_pkg::ADDR_W-1:0]  paddr,
    input  logic [dvr_pkg::DATA_W-1:0]  pwdata,
    output logic [dvr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    dvr_in_if.sink                      i_in,
    dvr_out_if.source                   o_out
);
    import dvr_pkg::*;

    t_cfg              w_cfg;
    logic [DIST_W-1:0] w_tmag;
    logic              w_adv;

    // Front end to divider
    logic              w_f_valid;
    logic [DVD_W-1:0]  w_f_dvd;
    t_side             w_f_side;

    // Divider to back end
    logic              w_d_valid;
    logic [QUO_W-1:0]  w_d_quo;
    logic              w_d_sat;
    t_side             w_d_side;

    // Back end result
    logic                    w_b_valid;
    logic signed [VEL_W-1:0] w_b_vel;
    logic [PHASE_W-1:0]      w_b_phase;

    // Skid register
    logic                    r_sk_valid;
    logic signed [VEL_W-1:0] r_sk_vel;
    logic [PHASE_W-1:0]      r_sk_phase;

    // The pipeline moves as a whole while the skid register is free.
    assign w_adv      = !r_sk_valid;
    assign i_in.ready = w_adv;

    // The divisor is |T|; a zero segment is caught in the phase.
    assign w_tmag = w_cfg.total_distance[DIST_W-1] ? DIST_W'(-w_cfg.total_distance)
                                                   : DIST_W'(w_cfg.total_distance);

    dvr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dvr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_tmag  (w_tmag),
        .i_adv   (w_adv),
        .i_valid (i_in.valid),
        .i_dist  (i_in.travelled_distance),
        .o_valid (w_f_valid),
        .o_dvd   (w_f_dvd),
        .o_side  (w_f_side)
    );

    dvr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (w_f_valid),
        .i_dvd     (w_f_dvd),
        .i_side    (w_f_side),
        .i_divisor (w_tmag),
        .o_valid   (w_d_valid),
        .o_quo     (w_d_quo),
        .o_sat     (w_d_sat),
        .o_side    (w_d_side)
    );

    dvr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_adv      (w_adv),
        .i_valid    (w_d_valid),
        .i_quo      (w_d_quo),
        .i_sat      (w_d_sat),
        .i_side     (w_d_side),
        .o_valid    (w_b_valid),
        .o_velocity (w_b_vel),
        .o_phase    (w_b_phase)
    );

    // A result that is not taken while the pipeline moves is parked in the
    // skid register; the pipeline then holds until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_valid <= 1'b0;
        end else if (r_sk_valid) begin
            if (o_out.ready) begin
                r_sk_valid <= 1'b0;
            end
        end else if (w_b_valid && !o_out.ready) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_valid) begin
            r_sk_vel   <= w_b_vel;
            r_sk_phase <= w_b_phase;
        end
    end

    assign o_out.valid    = r_sk_valid || w_b_valid;
    assign o_out.velocity = r_sk_valid ? r_sk_vel : w_b_vel;
    assign o_out.phase    = r_sk_valid ? r_sk_phase : w_b_phase;

endmodule

// ===== rtl/dvr_checker.sv =====
// ----------------------------------------------------------------------------
// dvr_checker
// Port-level checks of the ramp core, bound to the top level.
// ----------------------------------------------------------------------------
module dvr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dvr_pkg::VEL_W-1:0]   i_velocity,
    input logic [dvr_pkg::PHASE_W-1:0] i_phase
);
    import dvr_pkg::*;

    // A stalled output word stays and keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_velocity)
                                        && $stable(i_phase))
        else $error("output word changed while stalled");

    // A zero segment always commands standstill.
    a_zero_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_phase == PH_ZERO |-> i_velocity == '0)
        else $error("zero segment with nonzero velocity");

    // Input back-pressure only arises from a waiting output word.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no output pending");

    // Reset empties the pipeline and the skid register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind distance_velocity_ramp_core dvr_checker u_dvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_velocity  (o_out.velocity),
    .i_phase     (o_out.phase)
);
